// ----- src/m6502_pkg.sv -----
// Package for the 6502 execute unit: operation codes, flag bit positions
// and BCD adjust constants. No dependencies.
package m6502_pkg;

    // operation codes carried in the mode field
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_AND = 6'd1;
    localparam logic [5:0] OP_ASL = 6'd2;
    localparam logic [5:0] OP_BCC = 6'd3;
    localparam logic [5:0] OP_BCS = 6'd4;
    localparam logic [5:0] OP_BEQ = 6'd5;
    localparam logic [5:0] OP_BIT = 6'd6;
    localparam logic [5:0] OP_BMI = 6'd7;
    localparam logic [5:0] OP_BNE = 6'd8;
    localparam logic [5:0] OP_BPL = 6'd9;
    localparam logic [5:0] OP_BVC = 6'd10;
    localparam logic [5:0] OP_BVS = 6'd11;
    localparam logic [5:0] OP_CLC = 6'd12;
    localparam logic [5:0] OP_CLD = 6'd13;
    localparam logic [5:0] OP_CLI = 6'd14;
    localparam logic [5:0] OP_CLV = 6'd15;
    localparam logic [5:0] OP_CMP = 6'd16;
    localparam logic [5:0] OP_CPX = 6'd17;
    localparam logic [5:0] OP_CPY = 6'd18;
    localparam logic [5:0] OP_DEC = 6'd19;
    localparam logic [5:0] OP_DEX = 6'd20;
    localparam logic [5:0] OP_DEY = 6'd21;
    localparam logic [5:0] OP_EOR = 6'd22;
    localparam logic [5:0] OP_INC = 6'd23;
    localparam logic [5:0] OP_INX = 6'd24;
    localparam logic [5:0] OP_INY = 6'd25;
    localparam logic [5:0] OP_JMP = 6'd26;
    localparam logic [5:0] OP_LDA = 6'd27;
    localparam logic [5:0] OP_LDX = 6'd28;
    localparam logic [5:0] OP_LDY = 6'd29;
    localparam logic [5:0] OP_LSR = 6'd30;
    localparam logic [5:0] OP_ORA = 6'd31;
    localparam logic [5:0] OP_SBC = 6'd32;
    localparam logic [5:0] OP_SEC = 6'd33;
    localparam logic [5:0] OP_SED = 6'd34;
    localparam logic [5:0] OP_SEI = 6'd35;
    localparam logic [5:0] OP_STA = 6'd36;
    localparam logic [5:0] OP_STX = 6'd37;
    localparam logic [5:0] OP_STY = 6'd38;
    localparam logic [5:0] OP_TAX = 6'd39;
    localparam logic [5:0] OP_TAY = 6'd40;
    localparam logic [5:0] OP_TSX = 6'd41;
    localparam logic [5:0] OP_TXA = 6'd42;
    localparam logic [5:0] OP_TXS = 6'd43;
    localparam logic [5:0] OP_TYA = 6'd44;
    localparam logic [5:0] OP_COUNT = 6'd45;

    // status bit positions, NV-BDIZC
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // register values after reset
    localparam logic [7:0] SP_RESET = 8'hFF;

    // decimal adjust constants
    localparam logic [4:0] BCD_LO_LIMIT = 5'd10;
    localparam logic [3:0] BCD_STEP    = 4'd6;
    localparam logic [8:0] BCD_HI_LIMIT = 9'h0A0;
    localparam logic [9:0] BCD_HI_ADJ   = 10'h060;
    localparam logic [5:0] BCD_SUB_ADJ  = 6'd6;

    typedef logic [7:0] byte_t;

endpackage

// ----- src/mos6502_execute_unit.sv -----
// 6502 execute unit top level: register file, ALU with BCD add/subtract,
// flag logic and branch target add. Depends on m6502_pkg.
//
//   channel   direction  tdata (low bit first)                         tuser
//   s_        in         mode, operand, jump_target, pc_in (48 bits)   on_accumulator
//   m_        out        write_data, acc, x, y, status, pc (56 bits)   write_enable, invalid_op
//
// One operation per cycle unless a full output register stalls on m_tready: a
// word waits in the input register, where the ALU and flag logic read it with
// the architectural registers, then moves to the output register while A, X,
// Y, SP and P update at the same edge. m_tvalid rises with that move. aresetn
// (synchronous) clears A, X, Y, P to zero and SP to 0xFF and empties both stages.
// When m_tready is low the input register still takes one more word.
module mos6502_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[5:0], operand[13:6], jump_target[29:14], pc_in[45:30]
    input  logic        s_tuser,   // on_accumulator
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // write_data, acc_out, x_out, y_out, status_out, pc_out
    output logic [1:0]  m_tuser    // write_enable, invalid_op
);
    import m6502_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic [5:0]  mode_reg;
    byte_t       operand_reg;
    logic [15:0] target_reg;
    logic [15:0] pc_in_reg;
    logic        on_acc_reg;

    // architectural registers
    byte_t acc_reg, acc_next;
    byte_t x_reg, x_next;
    byte_t y_reg, y_next;
    byte_t sp_reg, sp_next;
    byte_t p_reg, p_next;

    // result stage
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // results of the current operation
    byte_t       wdata;
    logic        wen;
    logic [15:0] pc_next;
    logic        invalid;

    logic advance;
    logic s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            mode_reg    <= s_tdata[5:0];
            operand_reg <= s_tdata[13:6];
            target_reg  <= s_tdata[29:14];
            pc_in_reg   <= s_tdata[45:30];
            on_acc_reg  <= s_tuser;
        end
    end

    // binary add and subtract
    logic       c_in;
    logic [8:0] add_bin;
    logic [8:0] sub_bin;
    byte_t      sub_r;
    assign c_in    = p_reg[FLAG_C];
    assign add_bin = {1'b0, acc_reg} + {1'b0, operand_reg} + {8'd0, c_in};
    assign sub_bin = {1'b0, acc_reg} - {1'b0, operand_reg} - {8'd0, !c_in};
    assign sub_r   = sub_bin[7:0];

    // decimal add: low nibble adjust, then high adjust
    logic [4:0] dlo_sum;
    logic [4:0] dlo_adj;
    logic [8:0] dt;
    logic [9:0] dt_adj;
    logic [3:0] dlo_plus;
    assign dlo_sum  = {1'b0, acc_reg[3:0]} + {1'b0, operand_reg[3:0]} + {4'd0, c_in};
    assign dlo_plus = dlo_sum[3:0] + BCD_STEP;
    assign dlo_adj  = (dlo_sum >= BCD_LO_LIMIT) ? {1'b1, dlo_plus} : dlo_sum;
    assign dt       = {1'b0, acc_reg[7:4], 4'd0} + {1'b0, operand_reg[7:4], 4'd0}
                    + {4'd0, dlo_adj};
    assign dt_adj   = (dt >= BCD_HI_LIMIT) ? ({1'b0, dt} + BCD_HI_ADJ) : {1'b0, dt};

    // decimal subtract: nibble differences, sign in bit 5
    logic [5:0] slo, shi, slo_a, shi_a, shi_f;
    always_comb begin
        slo = {2'b0, acc_reg[3:0]} - {2'b0, operand_reg[3:0]} - {5'd0, !c_in};
        shi = {2'b0, acc_reg[7:4]} - {2'b0, operand_reg[7:4]};
        if (slo[5]) begin
            slo_a = slo - BCD_SUB_ADJ;
            shi_a = shi - 6'd1;
        end else begin
            slo_a = slo;
            shi_a = shi;
        end
        shi_f = shi_a[5] ? (shi_a - BCD_SUB_ADJ) : shi_a;
    end

    // compare source and difference
    byte_t      cmp_reg;
    logic [8:0] cmp_diff;
    always_comb begin
        case (mode_reg)
            OP_CPX:  cmp_reg = x_reg;
            OP_CPY:  cmp_reg = y_reg;
            default: cmp_reg = acc_reg;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand_reg};

    // shift source and result
    byte_t shift_src;
    byte_t shift_res;
    assign shift_src = on_acc_reg ? acc_reg : operand_reg;
    assign shift_res = (mode_reg == OP_ASL) ? {shift_src[6:0], 1'b0}
                                            : {1'b0, shift_src[7:1]};

    // memory inc and dec
    byte_t incdec;
    assign incdec = (mode_reg == OP_DEC) ? (operand_reg - 8'd1) : (operand_reg + 8'd1);

    // branch target
    logic [15:0] br_target;
    assign br_target = pc_in_reg + {{8{operand_reg[7]}}, operand_reg};

    // operation decode and register update
    always_comb begin
        byte_t nz_val;
        logic  nz_en;
        logic  take;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        p_next   = p_reg;
        wdata    = 8'd0;
        wen      = 1'b0;
        pc_next  = pc_in_reg;
        nz_val   = 8'd0;
        nz_en    = 1'b0;
        take     = 1'b0;
        invalid  = (mode_reg >= OP_COUNT);
        unique case (mode_reg) inside
            OP_ADC: begin
                if (p_reg[FLAG_D]) begin
                    p_next[FLAG_Z] = (add_bin[7:0] == 8'd0);
                    p_next[FLAG_N] = dt[7];
                    p_next[FLAG_V] = !(acc_reg[7] ^ operand_reg[7]) && (acc_reg[7] ^ dt[7]);
                    p_next[FLAG_C] = |dt_adj[9:8];
                    acc_next       = dt_adj[7:0];
                end else begin
                    p_next[FLAG_C] = add_bin[8];
                    p_next[FLAG_V] = !(acc_reg[7] ^ operand_reg[7])
                                     && (acc_reg[7] ^ add_bin[7]);
                    acc_next = add_bin[7:0];
                    nz_val   = add_bin[7:0];
                    nz_en    = 1'b1;
                end
            end
            OP_SBC: begin
                p_next[FLAG_C] = !sub_bin[8];
                p_next[FLAG_V] = (acc_reg[7] ^ operand_reg[7]) && (acc_reg[7] ^ sub_r[7]);
                nz_val = sub_r;
                nz_en  = 1'b1;
                acc_next = p_reg[FLAG_D] ? {shi_f[3:0], slo_a[3:0]} : sub_r;
            end
            OP_AND: begin
                acc_next = acc_reg & operand_reg;
                nz_val   = acc_next;
                nz_en    = 1'b1;
            end
            OP_EOR: begin
                acc_next = acc_reg ^ operand_reg;
                nz_val   = acc_next;
                nz_en    = 1'b1;
            end
            OP_ORA: begin
                acc_next = acc_reg | operand_reg;
                nz_val   = acc_next;
                nz_en    = 1'b1;
            end
            OP_ASL, OP_LSR: begin
                p_next[FLAG_C] = (mode_reg == OP_ASL) ? shift_src[7] : shift_src[0];
                nz_val = shift_res;
                nz_en  = 1'b1;
                if (on_acc_reg) begin
                    acc_next = shift_res;
                end else begin
                    wdata = shift_res;
                    wen   = 1'b1;
                end
            end
            OP_BCC: take = !p_reg[FLAG_C];
            OP_BCS: take = p_reg[FLAG_C];
            OP_BEQ: take = p_reg[FLAG_Z];
            OP_BNE: take = !p_reg[FLAG_Z];
            OP_BMI: take = p_reg[FLAG_N];
            OP_BPL: take = !p_reg[FLAG_N];
            OP_BVC: take = !p_reg[FLAG_V];
            OP_BVS: take = p_reg[FLAG_V];
            OP_BIT: begin
                p_next[FLAG_N] = operand_reg[7];
                p_next[FLAG_V] = operand_reg[6];
                p_next[FLAG_Z] = ((operand_reg & acc_reg) == 8'd0);
            end
            OP_CLC: p_next[FLAG_C] = 1'b0;
            OP_CLD: p_next[FLAG_D] = 1'b0;
            OP_CLI: p_next[FLAG_I] = 1'b0;
            OP_CLV: p_next[FLAG_V] = 1'b0;
            OP_SEC: p_next[FLAG_C] = 1'b1;
            OP_SED: p_next[FLAG_D] = 1'b1;
            OP_SEI: p_next[FLAG_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                p_next[FLAG_C] = !cmp_diff[8];
                nz_val = cmp_diff[7:0];
                nz_en  = 1'b1;
            end
            OP_DEC, OP_INC: begin
                nz_val = incdec;
                nz_en  = 1'b1;
                wdata  = incdec;
                wen    = 1'b1;
            end
            OP_DEX: begin
                x_next = x_reg - 8'd1;
                nz_val = x_next;
                nz_en  = 1'b1;
            end
            OP_DEY: begin
                y_next = y_reg - 8'd1;
                nz_val = y_next;
                nz_en  = 1'b1;
            end
            OP_INX: begin
                x_next = x_reg + 8'd1;
                nz_val = x_next;
                nz_en  = 1'b1;
            end
            OP_INY: begin
                y_next = y_reg + 8'd1;
                nz_val = y_next;
                nz_en  = 1'b1;
            end
            OP_JMP: pc_next = target_reg;
            OP_LDA: begin
                acc_next = operand_reg;
                nz_val   = operand_reg;
                nz_en    = 1'b1;
            end
            OP_LDX: begin
                x_next = operand_reg;
                nz_val = operand_reg;
                nz_en  = 1'b1;
            end
            OP_LDY: begin
                y_next = operand_reg;
                nz_val = operand_reg;
                nz_en  = 1'b1;
            end
            OP_STA: begin
                wdata = acc_reg;
                wen   = 1'b1;
            end
            OP_STX: begin
                wdata = x_reg;
                wen   = 1'b1;
            end
            OP_STY: begin
                wdata = y_reg;
                wen   = 1'b1;
            end
            OP_TAX: begin
                x_next = acc_reg;
                nz_val = acc_reg;
                nz_en  = 1'b1;
            end
            OP_TAY: begin
                y_next = acc_reg;
                nz_val = acc_reg;
                nz_en  = 1'b1;
            end
            OP_TSX: begin
                x_next = sp_reg;
                nz_val = sp_reg;
                nz_en  = 1'b1;
            end
            OP_TXA: begin
                acc_next = x_reg;
                nz_val   = x_reg;
                nz_en    = 1'b1;
            end
            OP_TXS: sp_next = x_reg;
            OP_TYA: begin
                acc_next = y_reg;
                nz_val   = y_reg;
                nz_en    = 1'b1;
            end
            default: ;
        endcase
        if (nz_en) begin
            p_next[FLAG_Z] = (nz_val == 8'd0);
            p_next[FLAG_N] = nz_val[7];
        end
        if (take) begin
            pc_next = br_target;
        end
    end

    // architectural registers update as the word moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 8'd0;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
            sp_reg  <= SP_RESET;
            p_reg   <= 8'd0;
        end else if (advance) begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            sp_reg  <= sp_next;
            p_reg   <= p_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= {pc_next, p_next, y_next, x_next, acc_next, wdata};
            out_user_reg <= {invalid, wen};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- tb/m6502_exec_monitor.sv -----
// Watches both stream channels of the 6502 execute unit, predicts each result
// word from the accepted input word, and compares field by field.
// Depends on m6502_pkg.
`timescale 1ns / 1ps

module m6502_exec_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[5:0], operand[13:6], jump_target[29:14], pc_in[45:30]
    input  logic        s_tuser,   // on_accumulator
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // write_data, acc_out, x_out, y_out, status_out, pc_out
    input  logic [1:0]  m_tuser,   // write_enable, invalid_op
    output int          fail_count,
    output int          pending
);
    import m6502_pkg::*;

    typedef struct packed {
        byte_t       wdata;
        logic        wen;
        byte_t       acc;
        byte_t       x;
        byte_t       y;
        byte_t       status;
        logic [15:0] pc;
        logic        invalid;
    } op_outcome_t;

    // architectural state as the predictor sees it
    byte_t reg_a, reg_x, reg_y, reg_sp, reg_p;

    op_outcome_t predicted_ops[$];

    function automatic void set_nz(byte_t v);
        reg_p[FLAG_Z] = (v == 8'h00);
        reg_p[FLAG_N] = v[7];
    endfunction

    function automatic void compare_with(byte_t rv, byte_t m);
        reg_p[FLAG_C] = (rv >= m);
        set_nz(byte_t'(rv - m));
    endfunction

    // executes one operation on the kept registers and returns the result word
    function automatic op_outcome_t run_instruction(logic [5:0] mode, byte_t opnd,
                                                    logic [15:0] target, logic [15:0] pc,
                                                    logic on_acc);
        op_outcome_t res;
        byte_t r;
        logic branch, take;
        int a, m, c, bin, lo, hi, t;
        res = '0;
        res.pc = pc;
        branch = 1'b0;
        take = 1'b0;
        case (mode)
            OP_ADC: begin
                a = reg_a;
                m = opnd;
                c = reg_p[FLAG_C];
                bin = a + m + c;
                if (reg_p[FLAG_D]) begin
                    // nmos decimal add: z from binary sum, n/v before high adjust
                    lo = (a & 'hF) + (m & 'hF) + c;
                    if (lo >= 10) lo = ((lo + 6) & 'hF) + 'h10;
                    t = (a & 'hF0) + (m & 'hF0) + lo;
                    reg_p[FLAG_Z] = ((bin & 'hFF) == 0);
                    reg_p[FLAG_N] = t[7];
                    reg_p[FLAG_V] = ((~(a ^ m)) & (a ^ t) & 'h80) != 0;
                    if (t >= 'hA0) t += 'h60;
                    reg_p[FLAG_C] = (t >= 'h100);
                    reg_a = t[7:0];
                end else begin
                    reg_p[FLAG_C] = (bin >= 'h100);
                    reg_p[FLAG_V] = ((~(a ^ m)) & (a ^ bin) & 'h80) != 0;
                    reg_a = bin[7:0];
                    set_nz(reg_a);
                end
            end
            OP_SBC: begin
                // flags always from the binary difference
                a = reg_a;
                m = opnd;
                c = !reg_p[FLAG_C];
                bin = (a - m - c) & 'h1FF;
                r = bin[7:0];
                reg_p[FLAG_C] = (a >= m + c);
                reg_p[FLAG_V] = ((a ^ m) & (a ^ r) & 'h80) != 0;
                set_nz(r);
                if (reg_p[FLAG_D]) begin
                    lo = (a & 'hF) - (m & 'hF) - c;
                    hi = (a >> 4) - (m >> 4);
                    if (lo < 0) begin
                        lo -= 6;
                        hi -= 1;
                    end
                    if (hi < 0) hi -= 6;
                    r = {hi[3:0], lo[3:0]};
                end
                reg_a = r;
            end
            OP_AND: begin reg_a = reg_a & opnd; set_nz(reg_a); end
            OP_EOR: begin reg_a = reg_a ^ opnd; set_nz(reg_a); end
            OP_ORA: begin reg_a = reg_a | opnd; set_nz(reg_a); end
            OP_ASL, OP_LSR: begin
                r = on_acc ? reg_a : opnd;
                if (mode == OP_ASL) begin
                    reg_p[FLAG_C] = r[7];
                    r = r << 1;
                end else begin
                    reg_p[FLAG_C] = r[0];
                    r = r >> 1;
                end
                set_nz(r);
                if (on_acc) begin
                    reg_a = r;
                end else begin
                    res.wdata = r;
                    res.wen = 1'b1;
                end
            end
            OP_BIT: begin
                reg_p[FLAG_N] = opnd[7];
                reg_p[FLAG_V] = opnd[6];
                reg_p[FLAG_Z] = ((opnd & reg_a) == 8'h00);
            end
            OP_BCC: begin branch = 1'b1; take = !reg_p[FLAG_C]; end
            OP_BCS: begin branch = 1'b1; take = reg_p[FLAG_C]; end
            OP_BEQ: begin branch = 1'b1; take = reg_p[FLAG_Z]; end
            OP_BNE: begin branch = 1'b1; take = !reg_p[FLAG_Z]; end
            OP_BMI: begin branch = 1'b1; take = reg_p[FLAG_N]; end
            OP_BPL: begin branch = 1'b1; take = !reg_p[FLAG_N]; end
            OP_BVS: begin branch = 1'b1; take = reg_p[FLAG_V]; end
            OP_BVC: begin branch = 1'b1; take = !reg_p[FLAG_V]; end
            OP_CLC: reg_p[FLAG_C] = 1'b0;
            OP_CLD: reg_p[FLAG_D] = 1'b0;
            OP_CLI: reg_p[FLAG_I] = 1'b0;
            OP_CLV: reg_p[FLAG_V] = 1'b0;
            OP_SEC: reg_p[FLAG_C] = 1'b1;
            OP_SED: reg_p[FLAG_D] = 1'b1;
            OP_SEI: reg_p[FLAG_I] = 1'b1;
            OP_CMP: compare_with(reg_a, opnd);
            OP_CPX: compare_with(reg_x, opnd);
            OP_CPY: compare_with(reg_y, opnd);
            OP_DEC, OP_INC: begin
                r = (mode == OP_DEC) ? byte_t'(opnd - 8'd1) : byte_t'(opnd + 8'd1);
                set_nz(r);
                res.wdata = r;
                res.wen = 1'b1;
            end
            OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            OP_JMP: res.pc = target;
            OP_LDA: begin reg_a = opnd; set_nz(opnd); end
            OP_LDX: begin reg_x = opnd; set_nz(opnd); end
            OP_LDY: begin reg_y = opnd; set_nz(opnd); end
            OP_STA: begin res.wdata = reg_a; res.wen = 1'b1; end
            OP_STX: begin res.wdata = reg_x; res.wen = 1'b1; end
            OP_STY: begin res.wdata = reg_y; res.wen = 1'b1; end
            OP_TAX: begin reg_x = reg_a; set_nz(reg_x); end
            OP_TAY: begin reg_y = reg_a; set_nz(reg_y); end
            OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
            OP_TXA: begin reg_a = reg_x; set_nz(reg_a); end
            OP_TXS: reg_sp = reg_x;
            OP_TYA: begin reg_a = reg_y; set_nz(reg_a); end
            default: ;
        endcase
        // taken branch: sign-extended offset, wraps at 64k
        if (branch && take) res.pc = pc + {{8{opnd[7]}}, opnd};
        res.acc = reg_a;
        res.x = reg_x;
        res.y = reg_y;
        res.status = reg_p;
        res.invalid = (mode >= OP_COUNT);
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, name,
                         exp_v, act_v);
        end
    endtask

    // sample at the falling edge: inputs only move at the rising edge
    always @(negedge aclk) begin
        op_outcome_t want;
        if (!aresetn) begin
            reg_a = 8'h00;
            reg_x = 8'h00;
            reg_y = 8'h00;
            reg_sp = SP_RESET;
            reg_p = 8'h00;
            predicted_ops.delete();
        end else begin
            // result word leaving the block
            if (m_tvalid && m_tready) begin
                if (predicted_ops.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t result word with none predicted: %h / %b", $realtime,
                                 m_tdata, m_tuser);
                end else begin
                    want = predicted_ops.pop_front();
                    check_field("write_data", {8'h00, want.wdata}, {8'h00, m_tdata[7:0]});
                    check_field("write_enable", {15'd0, want.wen}, {15'd0, m_tuser[0]});
                    check_field("acc_out", {8'h00, want.acc}, {8'h00, m_tdata[15:8]});
                    check_field("x_out", {8'h00, want.x}, {8'h00, m_tdata[23:16]});
                    check_field("y_out", {8'h00, want.y}, {8'h00, m_tdata[31:24]});
                    check_field("status_out", {8'h00, want.status}, {8'h00, m_tdata[39:32]});
                    check_field("pc_out", want.pc, m_tdata[55:40]);
                    check_field("invalid_op", {15'd0, want.invalid}, {15'd0, m_tuser[1]});
                end
            end
            // operation word entering the block
            if (s_tvalid && s_tready)
                predicted_ops.push_back(run_instruction(s_tdata[5:0], s_tdata[13:6],
                                                        s_tdata[29:14], s_tdata[45:30],
                                                        s_tuser));
        end
        pending = predicted_ops.size();
    end

endmodule

// ----- tb/tb.sv -----
// Top of the execute unit testbench: clock, reset, operation stimulus, result
// back-pressure and verdict. Depends on m6502_pkg, mos6502_execute_unit and
// m6502_exec_monitor.
`timescale 1ns / 1ps

module tb;
    import m6502_pkg::*;

    localparam int          NUM_RANDOM     = 900;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [5:0]  MODE_MAX       = 6'd63;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;
    wire  [1:0]  m_tuser;

    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    logic idle_on      = 1'b1;
    logic long_hold    = 1'b0;

    mos6502_execute_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    m6502_exec_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one operation word, with an optional idle burst in front
    task automatic send_op(logic [5:0] mode, byte_t operand, logic [15:0] target,
                           logic [15:0] pc, logic on_acc);
        logic ready_seen;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pc, target, operand, mode};
        s_tuser  <= on_acc;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [5:0] mode;
        byte_t      operand;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset values, decimal corners, overflow, wraps, invalid codes
        send_op(OP_TSX, 8'h00, 16'h0000, 16'h0200, 1'b0);
        send_op(OP_LDA, 8'h00, 16'h0000, 16'h0201, 1'b0);
        send_op(OP_LDA, 8'h99, 16'h0000, 16'h0202, 1'b0);
        send_op(OP_SED, 8'h00, 16'h0000, 16'h0203, 1'b0);
        send_op(OP_ADC, 8'h01, 16'h0000, 16'h0204, 1'b0);
        send_op(OP_ADC, 8'hFF, 16'h0000, 16'h0205, 1'b0);
        send_op(OP_SEC, 8'h00, 16'h0000, 16'h0206, 1'b0);
        send_op(OP_SBC, 8'h01, 16'h0000, 16'h0207, 1'b0);
        send_op(OP_CLC, 8'h00, 16'h0000, 16'h0208, 1'b0);
        send_op(OP_SBC, 8'h99, 16'h0000, 16'h0209, 1'b0);
        send_op(OP_CLD, 8'h00, 16'h0000, 16'h020A, 1'b0);
        send_op(OP_LDA, 8'h7F, 16'h0000, 16'h020B, 1'b0);
        send_op(OP_ADC, 8'h01, 16'h0000, 16'h020C, 1'b0);
        send_op(OP_SBC, 8'hFF, 16'h0000, 16'h020D, 1'b0);
        send_op(OP_CMP, 8'hFF, 16'h0000, 16'h020E, 1'b0);
        send_op(OP_CPX, 8'h00, 16'h0000, 16'h020F, 1'b0);
        send_op(OP_CPY, 8'h80, 16'h0000, 16'h0210, 1'b0);
        send_op(OP_LSR, 8'hFF, 16'h0000, 16'h0211, 1'b0);
        send_op(OP_ASL, 8'h00, 16'h0000, 16'h0212, 1'b1);
        send_op(OP_BIT, 8'hC0, 16'h0000, 16'h0213, 1'b0);
        send_op(OP_BMI, 8'h80, 16'h0000, 16'h0010, 1'b0);
        send_op(OP_BVS, 8'h7F, 16'h0000, 16'hFFF0, 1'b0);
        send_op(OP_JMP, 8'h00, 16'hFFFF, 16'h0214, 1'b0);
        send_op(OP_COUNT, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_op(MODE_MAX, 8'h00, 16'h0000, 16'h0000, 1'b0);

        // random operations, mostly valid, with decimal-shaped operands often
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 300) long_hold = 1'b1;
            if (i == 550) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            if (i == NUM_RANDOM - 100) idle_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
                mode = 6'($urandom_range(OP_COUNT, MODE_MAX));
            else
                mode = 6'($urandom_range(0, OP_COUNT - 1));
            case ($urandom_range(0, 3))
                0: operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                1: begin
                    case ($urandom_range(0, 4))
                        0: operand = 8'h00;
                        1: operand = 8'hFF;
                        2: operand = 8'h7F;
                        3: operand = 8'h80;
                        default: operand = 8'h01;
                    endcase
                end
                default: operand = 8'($urandom);
            endcase
            send_op(mode, operand, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
